// ===== src/sfd_pkg.sv =====
// Package for the servo frame deframer: phase and status codes, register
// indexes, reset values and the result type. No dependencies.
`default_nettype none
package sfd_pkg;

  localparam int unsigned DATA_LEN = 6;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned IDX_W    = 2;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_SYNC = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_TAIL = 2'd1,
    ST_BAD_SUM  = 2'd2,
    ST_TIMEOUT  = 2'd3
  } status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_HEADER_FIRST  = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_TAIL_VALUE    = 2'd2,
    REG_TIMEOUT_TICKS = 2'd3
  } reg_index_t;

  localparam logic [7:0]  HEADER_FIRST_RST  = 8'd250;
  localparam logic [7:0]  HEADER_SECOND_RST = 8'd175;
  localparam logic [7:0]  TAIL_VALUE_RST    = 8'd237;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd0;

  localparam logic [POS_W-1:0] POS_SUM  = 3'd6;
  localparam logic [POS_W-1:0] POS_TAIL = 3'd7;

  typedef struct packed {
    status_t    status;
    logic [7:0] id_byte;
    logic [7:0] command_byte;
    logic [7:0] data_byte_0;
    logic [7:0] data_byte_1;
    logic [7:0] data_byte_2;
    logic [7:0] data_byte_3;
  } result_t;

endpackage
`default_nettype wire

// ===== src/sfd_item_if.sv =====
// Input channel of the servo frame deframer: received byte or timer tick.
// Valid/ready handshake; no dependencies.
`default_nettype none
interface sfd_item_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== src/sfd_result_if.sv =====
// Result channel of the servo frame deframer: frame status and body bytes.
// Valid/ready handshake; no dependencies.
`default_nettype none
interface sfd_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] id_byte;
  logic [7:0] command_byte;
  logic [7:0] data_byte_0;
  logic [7:0] data_byte_1;
  logic [7:0] data_byte_2;
  logic [7:0] data_byte_3;

  modport source (output valid, output status, output id_byte, output command_byte,
                  output data_byte_0, output data_byte_1, output data_byte_2,
                  output data_byte_3, input ready);
  modport sink   (input valid, input status, input id_byte, input command_byte,
                  input data_byte_0, input data_byte_1, input data_byte_2,
                  input data_byte_3, output ready);
endinterface
`default_nettype wire

// ===== src/servo_frame_deframer_unit.sv =====
// Servo frame deframer top level: frame hunt, body collection, checks and
// a two-entry result buffer. Depends on sfd_pkg, sfd_item_if, sfd_result_if.
//
// Takes one transaction per clock: a received byte or a timer tick. Frames are
// header_first, header_second, six body bytes, a checksum byte (wrapping sum of
// the body) and the tail byte. The state update for an item is done in the cycle
// it is accepted and its result, if any, is registered into the result buffer.
// Results sit in a two-entry buffer, so input keeps flowing while one result
// waits; items stall only while both entries are full, even in a cycle
// in which the head is being taken. timeout_ticks counts ticks from the first
// header byte; zero turns the timeout off. Configuration writes take effect on
// the next clock.
`default_nettype none
module servo_frame_deframer_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  sfd_item_if.sink                         items,
  sfd_result_if.source                     results,
  input  wire logic                        cfg_wr_en,
  input  wire logic [sfd_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [sfd_pkg::CFG_W-1:0]   cfg_data
);

  logic [7:0]  header_first;
  logic [7:0]  header_second;
  logic [7:0]  tail_value;
  logic [15:0] timeout_ticks;

  sfd_pkg::phase_t             phase, phase_next;
  logic [sfd_pkg::POS_W-1:0]   byte_position, byte_position_next;
  logic [7:0]                  running_sum, running_sum_next;
  logic [15:0]                 tick_count, tick_count_next;
  logic [7:0]                  frame_bytes [sfd_pkg::DATA_LEN];
  logic                        store_en;

  logic [15:0]       tick_inc;
  logic              has_result;
  sfd_pkg::result_t  result_new;

  sfd_pkg::result_t  head, skid;
  logic              head_valid, skid_valid;
  logic              accept, push, pop;

  assign items.ready = !skid_valid;
  assign accept      = items.valid && items.ready;
  assign pop         = head_valid && results.ready;
  assign push        = accept && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= sfd_pkg::HEADER_FIRST_RST;
      header_second <= sfd_pkg::HEADER_SECOND_RST;
      tail_value    <= sfd_pkg::TAIL_VALUE_RST;
      timeout_ticks <= sfd_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_wr_en) begin
      unique case (sfd_pkg::reg_index_t'(cfg_index))
        sfd_pkg::REG_HEADER_FIRST:  header_first  <= cfg_data[7:0];
        sfd_pkg::REG_HEADER_SECOND: header_second <= cfg_data[7:0];
        sfd_pkg::REG_TAIL_VALUE:    tail_value    <= cfg_data[7:0];
        sfd_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign tick_inc = (tick_count != 16'hFFFF) ? tick_count + 16'd1 : tick_count;

  // Next state
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    tick_count_next    = tick_count;
    store_en           = 1'b0;
    if (items.func) begin
      if ((phase == sfd_pkg::PH_SYNC || phase == sfd_pkg::PH_BODY) &&
          timeout_ticks != 16'd0) begin
        if (tick_inc >= timeout_ticks) begin
          phase_next         = sfd_pkg::PH_HUNT;
          byte_position_next = '0;
          running_sum_next   = '0;
          tick_count_next    = '0;
        end else begin
          tick_count_next = tick_inc;
        end
      end
    end else begin
      unique case (phase)
        sfd_pkg::PH_SYNC: begin
          byte_position_next = '0;
          running_sum_next   = '0;
          if (items.rx_byte == header_second) begin
            phase_next = sfd_pkg::PH_BODY;
          end else begin
            phase_next      = sfd_pkg::PH_HUNT;
            tick_count_next = '0;
          end
        end
        sfd_pkg::PH_BODY: begin
          if (byte_position < sfd_pkg::POS_SUM) begin
            store_en           = 1'b1;
            running_sum_next   = running_sum + items.rx_byte;
            byte_position_next = byte_position + 1'b1;
          end else if (byte_position == sfd_pkg::POS_SUM) begin
            running_sum_next   = running_sum - items.rx_byte;
            byte_position_next = sfd_pkg::POS_TAIL;
          end else begin
            phase_next         = sfd_pkg::PH_HUNT;
            byte_position_next = '0;
            running_sum_next   = '0;
            tick_count_next    = '0;
          end
        end
        default: begin
          byte_position_next = '0;
          running_sum_next   = '0;
          tick_count_next    = '0;
          phase_next = (items.rx_byte == header_first) ? sfd_pkg::PH_SYNC
                                                       : sfd_pkg::PH_HUNT;
        end
      endcase
    end
  end

  // Result for the current item
  always_comb begin
    has_result              = 1'b0;
    result_new.status       = sfd_pkg::ST_OK;
    result_new.id_byte      = frame_bytes[0];
    result_new.command_byte = frame_bytes[1];
    result_new.data_byte_0  = frame_bytes[2];
    result_new.data_byte_1  = frame_bytes[3];
    result_new.data_byte_2  = frame_bytes[4];
    result_new.data_byte_3  = frame_bytes[5];
    if (items.func) begin
      if ((phase == sfd_pkg::PH_SYNC || phase == sfd_pkg::PH_BODY) &&
          timeout_ticks != 16'd0 && tick_inc >= timeout_ticks) begin
        has_result              = 1'b1;
        result_new.status       = sfd_pkg::ST_TIMEOUT;
        result_new.id_byte      = '0;
        result_new.command_byte = '0;
        result_new.data_byte_0  = '0;
        result_new.data_byte_1  = '0;
        result_new.data_byte_2  = '0;
        result_new.data_byte_3  = '0;
      end
    end else if (phase == sfd_pkg::PH_BODY && byte_position == sfd_pkg::POS_TAIL) begin
      has_result = 1'b1;
      priority if (items.rx_byte != tail_value) begin
        result_new.status = sfd_pkg::ST_BAD_TAIL;
      end else if (running_sum != 8'd0) begin
        result_new.status = sfd_pkg::ST_BAD_SUM;
      end else begin
        result_new.status = sfd_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sfd_pkg::PH_HUNT;
      byte_position <= '0;
      running_sum   <= '0;
      tick_count    <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      tick_count    <= tick_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_en) begin
      frame_bytes[byte_position] <= items.rx_byte;
    end
  end

  // Two-entry result buffer, head first
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        head_valid <= 1'b1;
        skid_valid <= push;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      if (head_valid) begin
        skid_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        head <= skid;
        if (push) begin
          skid <= result_new;
        end
      end else if (push) begin
        head <= result_new;
      end
    end else if (push) begin
      if (head_valid) begin
        skid <= result_new;
      end else begin
        head <= result_new;
      end
    end
  end

  assign results.valid        = head_valid;
  assign results.status       = head.status;
  assign results.id_byte      = head.id_byte;
  assign results.command_byte = head.command_byte;
  assign results.data_byte_0  = head.data_byte_0;
  assign results.data_byte_1  = head.data_byte_1;
  assign results.data_byte_2  = head.data_byte_2;
  assign results.data_byte_3  = head.data_byte_3;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for servo_frame_deframer_unit: directed and random byte/tick traffic
// with a transaction-level frame predictor and an in-order result scoreboard.
// Depends on sfd_pkg, sfd_item_if, sfd_result_if and the deframer RTL.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned ITEM_TARGET = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en;
  logic [sfd_pkg::IDX_W-1:0] cfg_index;
  logic [sfd_pkg::CFG_W-1:0] cfg_data;

  sfd_item_if   item_ch ();
  sfd_result_if res_ch ();

  servo_frame_deframer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .items     (item_ch),
    .results   (res_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  logic [7:0]       hdr_first;
  logic [7:0]       hdr_second;
  logic [7:0]       tail_byte;
  logic [15:0]      tick_limit;
  sfd_pkg::phase_t  ph;
  int unsigned      body_pos;
  logic [7:0]       body_bytes [sfd_pkg::DATA_LEN];
  logic [7:0]       sum_acc;
  logic [15:0]      tick_cnt;

  sfd_pkg::result_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  bit          tx_idle_en;
  bit          rx_stall_en;
  int unsigned stall_left = 0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void go_hunt();
    ph = sfd_pkg::PH_HUNT;
    body_pos = 0;
    sum_acc = 8'd0;
    tick_cnt = 16'd0;
  endfunction

  function automatic void advance_deframer(input logic f, input logic [7:0] b);
    sfd_pkg::result_t r;
    r = '0;
    if (f) begin
      if ((ph == sfd_pkg::PH_SYNC || ph == sfd_pkg::PH_BODY) && tick_limit != 16'd0) begin
        if (tick_cnt != 16'hFFFF) tick_cnt++;
        if (tick_cnt >= tick_limit) begin
          go_hunt();
          r.status = sfd_pkg::ST_TIMEOUT;
          pending_results.push_back(r);
        end
      end
    end else begin
      case (ph)
        sfd_pkg::PH_SYNC: begin
          if (b == hdr_second) begin
            ph = sfd_pkg::PH_BODY;
            body_pos = 0;
            sum_acc = 8'd0;
          end else begin
            go_hunt();
          end
        end
        sfd_pkg::PH_BODY: begin
          if (body_pos < sfd_pkg::DATA_LEN) begin
            body_bytes[body_pos] = b;
            sum_acc += b;
            body_pos++;
          end else if (body_pos == sfd_pkg::DATA_LEN) begin
            sum_acc -= b;
            body_pos++;
          end else begin
            if (b != tail_byte) r.status = sfd_pkg::ST_BAD_TAIL;
            else if (sum_acc != 8'd0) r.status = sfd_pkg::ST_BAD_SUM;
            else r.status = sfd_pkg::ST_OK;
            r.id_byte      = body_bytes[0];
            r.command_byte = body_bytes[1];
            r.data_byte_0  = body_bytes[2];
            r.data_byte_1  = body_bytes[3];
            r.data_byte_2  = body_bytes[4];
            r.data_byte_3  = body_bytes[5];
            pending_results.push_back(r);
            go_hunt();
          end
        end
        default: begin
          if (b == hdr_first) begin
            ph = sfd_pkg::PH_SYNC;
            body_pos = 0;
            sum_acc = 8'd0;
            tick_cnt = 16'd0;
          end else begin
            go_hunt();
          end
        end
      endcase
    end
  endfunction

  function automatic string fmt_result(input sfd_pkg::result_t r);
    return $sformatf("status=%0d bytes=%h %h %h %h %h %h", r.status, r.id_byte,
                     r.command_byte, r.data_byte_0, r.data_byte_1, r.data_byte_2,
                     r.data_byte_3);
  endfunction

  always @(posedge clk) begin : check_results
    sfd_pkg::result_t got;
    sfd_pkg::result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.status       = sfd_pkg::status_t'(res_ch.status);
      got.id_byte      = res_ch.id_byte;
      got.command_byte = res_ch.command_byte;
      got.data_byte_0  = res_ch.data_byte_0;
      got.data_byte_1  = res_ch.data_byte_1;
      got.data_byte_2  = res_ch.data_byte_2;
      got.data_byte_3  = res_ch.data_byte_3;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", fmt_result(got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %s, got %s", fmt_result(want), fmt_result(got));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      if (rx_stall_en) stall_left = pick_gap();
    end
  end

  task automatic send_item(input logic f, input logic [7:0] b);
    int unsigned gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.func    <= f;
    item_ch.rx_byte <= b;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    advance_deframer(f, b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input sfd_pkg::reg_index_t idx, input logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      sfd_pkg::REG_HEADER_FIRST:  hdr_first  = v[7:0];
      sfd_pkg::REG_HEADER_SECOND: hdr_second = v[7:0];
      sfd_pkg::REG_TAIL_VALUE:    tail_byte  = v[7:0];
      sfd_pkg::REG_TIMEOUT_TICKS: tick_limit = v;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] body [sfd_pkg::DATA_LEN], input bit sum_err,
                            input bit tail_err, input int unsigned tick_pct);
    logic [7:0] chk;
    logic [7:0] frame_seq [10];
    chk = 8'd0;
    for (int i = 0; i < sfd_pkg::DATA_LEN; i++) chk += body[i];
    if (sum_err) chk += 8'($urandom_range(1, 255));
    frame_seq[0] = hdr_first;
    frame_seq[1] = hdr_second;
    for (int i = 0; i < sfd_pkg::DATA_LEN; i++) frame_seq[2 + i] = body[i];
    frame_seq[8] = chk;
    frame_seq[9] = tail_err ? tail_byte ^ 8'($urandom_range(1, 255)) : tail_byte;
    for (int i = 0; i < 10; i++) begin
      if ($urandom_range(0, 99) < tick_pct) send_item(1'b1, 8'($urandom));
      send_item(1'b0, frame_seq[i]);
    end
  endtask

  task automatic test_frame_checks();
    logic [7:0] body [sfd_pkg::DATA_LEN];
    body = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80};
    send_frame(body, 1'b0, 1'b0, 0);
    body = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame(body, 1'b1, 1'b1, 0);
    wait_idle();
  endtask

  task automatic test_header_hunt();
    send_item(1'b0, hdr_first);
    send_item(1'b0, hdr_first);
    send_item(1'b0, hdr_second);
    send_item(1'b1, 8'hFF);
    send_item(1'b0, 8'h00);
    wait_idle();
  endtask

  task automatic test_timeout();
    logic [7:0] body [sfd_pkg::DATA_LEN];
    write_reg(sfd_pkg::REG_TIMEOUT_TICKS, 16'd1);
    send_item(1'b0, hdr_first);
    send_item(1'b1, 8'h00);
    wait_idle();
    write_reg(sfd_pkg::REG_TIMEOUT_TICKS, 16'd100);
    send_item(1'b0, hdr_first);
    send_item(1'b0, hdr_second);
    send_item(1'b1, 8'h00);
    send_item(1'b1, 8'h00);
    wait_idle();
    write_reg(sfd_pkg::REG_TIMEOUT_TICKS, 16'd2);
    send_item(1'b1, 8'h00);
    wait_idle();
    write_reg(sfd_pkg::REG_TIMEOUT_TICKS, 16'hFFFF);
    send_item(1'b1, 8'h00);
    body = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC};
    send_frame(body, 1'b0, 1'b0, 30);
    wait_idle();
  endtask

  function automatic logic [15:0] pick_byte_reg();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return {8'($urandom), 8'h00};
    if (r < 40) return {8'($urandom), 8'hFF};
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_tick_limit();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'($urandom_range(2, 12));
      3: return 16'hFFFF;
      4: return 16'($urandom);
      default: return 16'($urandom_range(13, 40));
    endcase
  endfunction

  task automatic test_random_traffic();
    logic [7:0]  body [sfd_pkg::DATA_LEN];
    int unsigned kind;
    int unsigned n;
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      write_reg(sfd_pkg::REG_HEADER_FIRST, pick_byte_reg());
      write_reg(sfd_pkg::REG_HEADER_SECOND, pick_byte_reg());
      write_reg(sfd_pkg::REG_TAIL_VALUE, pick_byte_reg());
      write_reg(sfd_pkg::REG_TIMEOUT_TICKS, pick_tick_limit());
      n = $urandom_range(0, 3);
      tx_idle_en  = n[0];
      rx_stall_en = n[1];
      repeat ($urandom_range(5, 15)) begin
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
          for (int i = 0; i < sfd_pkg::DATA_LEN; i++) body[i] = 8'($urandom);
          send_frame(body, $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 15,
                     ($urandom_range(0, 99) < 20) ? 15 : 0);
        end else if (kind < 75) begin
          repeat ($urandom_range(1, 5)) send_item(1'($urandom), 8'($urandom));
        end else if (kind < 85) begin
          send_item(1'b0, hdr_first);
          if ($urandom_range(0, 1)) begin
            send_item(1'b0, hdr_first);
            send_item(1'b0, hdr_second);
          end else begin
            send_item(1'b0, 8'($urandom));
          end
        end else if (kind < 95) begin
          send_item(1'b0, hdr_first);
          if ($urandom_range(0, 1)) begin
            send_item(1'b0, hdr_second);
            repeat ($urandom_range(0, 7)) send_item(1'b0, 8'($urandom));
          end
          n = (tick_limit != 16'd0 && tick_limit <= 16'd40) ? tick_limit
                                                            : $urandom_range(1, 4);
          repeat (n) send_item(1'b1, 8'($urandom));
        end else begin
          wait_idle();
        end
      end
    end
  endtask

  initial begin
    item_ch.valid   = 1'b0;
    item_ch.func    = 1'b0;
    item_ch.rx_byte = 8'd0;
    cfg_wr_en       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    tx_idle_en      = 1'b1;
    rx_stall_en     = 1'b1;
    hdr_first       = sfd_pkg::HEADER_FIRST_RST;
    hdr_second      = sfd_pkg::HEADER_SECOND_RST;
    tail_byte       = sfd_pkg::TAIL_VALUE_RST;
    tick_limit      = sfd_pkg::TIMEOUT_TICKS_RST;
    go_hunt();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_frame_checks();
    test_header_hunt();
    test_timeout();
    test_random_traffic();

    wait_idle();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
